// File: hdl/dsmc_pkg.sv
// dsmc_pkg: sizes and shared types for the distance set mark checker.
// Used by dsmc_dist_map and distance_set_mark_checker; depends on nothing.
package dsmc_pkg;

   localparam int DIST_RANGE = 1024;
   localparam int MAX_MARKS  = 32;
   localparam int WORD_BITS  = 64;

   localparam int POS_W      = 10;
   localparam int DIST_W     = $clog2(DIST_RANGE);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int NUM_ROWS   = (DIST_RANGE + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_IDX_W  = DIST_W - BIT_W;
   localparam int MARK_IDX_W = $clog2(MAX_MARKS);
   localparam int COUNT_W    = 6;
   localparam int LIMIT_W    = 11;

   // Requests from the sequencer to the distance bitmap.
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic              wr_en;
      logic [DIST_W-1:0] delta;
   } dsmc_map_ctl_type;

endpackage

// File: hdl/dsmc_dist_map.sv
// dsmc_dist_map: used-distance bitmap, rows of WORD_BITS in a memory,
// with a valid flop per row so that a clear empties all rows at once. Depends on dsmc_pkg.
module dsmc_dist_map
   import dsmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dsmc_map_ctl_type ctl,
   output logic             hit
);

   logic [WORD_BITS-1:0] rows_mem [NUM_ROWS];
   logic [NUM_ROWS-1:0]  row_valid_ff;
   logic [NUM_ROWS-1:0]  row_valid_in;
   logic [WORD_BITS-1:0] row_data_ff;
   logic                 row_vld_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [WORD_BITS-1:0] wr_row;
   logic [ROW_IDX_W-1:0] rd_row;
   logic [ROW_IDX_W-1:0] wr_row_idx;

   assign rd_row     = ctl.delta[DIST_W-1:BIT_W];
   assign wr_row_idx = dist_ff[DIST_W-1:BIT_W];

   // Merge the set bit into the row fetched for this distance.
   assign wr_row = (row_vld_ff ? row_data_ff : '0)
                 | ({{(WORD_BITS-1){1'b0}}, 1'b1} << dist_ff[BIT_W-1:0]);
   assign hit    = row_vld_ff & row_data_ff[dist_ff[BIT_W-1:0]];

   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctl.clear) begin
         row_valid_in = '0;
      end else if (ctl.wr_en) begin
         row_valid_in[wr_row_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         rows_mem[wr_row_idx] <= wr_row;
      end
      if (ctl.rd_en) begin
         row_data_ff <= rows_mem[rd_row];
         row_vld_ff  <= row_valid_ff[rd_row];
         dist_ff     <= ctl.delta;
      end
   end

endmodule

// File: hdl/distance_set_mark_checker.sv
// distance_set_mark_checker: top level, sequencer, mark store and APB register.
// Depends on dsmc_pkg and dsmc_dist_map.
//
// The block holds up to 32 ruler marks in ascending order and a 1024-bit map
// of distances already used between them. A word on the request channel is a
// check (is the position free of used distances to every stored mark), an add
// (record all distances to the stored marks, then insert the position in
// order) or a clear (empty the marks and the map at once). Distances at
// or above the distance cap (register 0, reset 1024, saturated to 1024) are
// never recorded and never collide. One request is worked at a time and
// req_ready is low meanwhile. A check or add walks the stored marks with one
// shared absolute-difference unit from the top down, with a mark store read
// and a bitmap row read-modify-write per mark. Clear, a full add, an add or
// check on an empty store and the unused request code go straight to the
// result word. A check stops at the first collision. The result word sits in
// an output register, so the next request is taken while a result still
// waits for rsp_ready, but a further result waits until that slot frees.
module distance_set_mark_checker
   import dsmc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [POS_W-1:0]   req_position,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [COUNT_W-1:0] rsp_mark_count,
   output logic               rsp_overflow,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [1:0] REQ_CHECK = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic       REG_DIST_CAP = 1'b0;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(1024);
   localparam logic [LIMIT_W-1:0]  LIMIT_MAX   = LIMIT_W'(DIST_RANGE);
   localparam logic [COUNT_W-1:0]  COUNT_FULL  = COUNT_W'(MAX_MARKS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIST,
      ST_UPD,
      ST_DONE
   } state_type;

   // sequencer state
   state_type             state_ff, state_in;
   logic [1:0]            type_ff, type_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [MARK_IDX_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  shift_ff, shift_in;
   logic                  inlim_ff, inlim_in;
   logic                  res_acc_ff, res_acc_in;
   logic                  res_ovf_ff, res_ovf_in;
   // result slot
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   // register
   logic [LIMIT_W-1:0]    dist_cap_ff, dist_cap_in;

   // mark store
   logic [POS_W-1:0]      marks_mem [MAX_MARKS];
   logic [POS_W-1:0]      mark_q_ff;
   logic                  mk_re;
   logic [MARK_IDX_W-1:0] mk_raddr;
   logic                  mk_we;
   logic [MARK_IDX_W-1:0] mk_waddr;
   logic [POS_W-1:0]      mk_wdata;

   // shared difference unit
   logic [POS_W-1:0]      diff;
   logic [LIMIT_W-1:0]    limit;
   logic                  csr_wr;

   dsmc_map_ctl_type      map_ctl;
   logic                  map_hit;

   dsmc_dist_map u_map (
      .clock (clock),
      .reset (reset),
      .ctl   (map_ctl),
      .hit   (map_hit)
   );

   assign diff  = (pos_ff >= mark_q_ff) ? (pos_ff - mark_q_ff) : (mark_q_ff - pos_ff);
   assign limit = (dist_cap_ff > LIMIT_MAX) ? LIMIT_MAX : dist_cap_ff;

   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DIST_CAP) ? {{(32-LIMIT_W){1'b0}}, dist_cap_ff} : '0;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_mark_count = rsp_cnt_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      inlim_in     = inlim_ff;
      res_acc_in   = res_acc_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      dist_cap_in  = dist_cap_ff;

      mk_re    = 1'b0;
      mk_raddr = idx_ff;
      mk_we    = 1'b0;
      mk_waddr = idx_ff;
      mk_wdata = pos_ff;

      map_ctl       = '0;
      map_ctl.delta = diff;

      // Drop the result word once taken; a new one may refill below.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr && (paddr[2] == REG_DIST_CAP)) begin
         dist_cap_in = pwdata[LIMIT_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in    = req_type;
               pos_in     = req_position;
               res_ovf_in = 1'b0;
               idx_in     = MARK_IDX_W'(count_ff - COUNT_W'(1));
               state_in   = ST_DONE;
               case (req_type)
                  REQ_CHECK: begin
                     res_acc_in = 1'b1;
                     if (count_ff != '0) begin
                        // Start the walk at the top mark.
                        mk_re    = 1'b1;
                        mk_raddr = MARK_IDX_W'(count_ff - COUNT_W'(1));
                        state_in = ST_DIST;
                     end
                  end
                  REQ_ADD: begin
                     if (count_ff == COUNT_FULL) begin
                        res_acc_in = 1'b0;
                        res_ovf_in = 1'b1;
                     end else if (count_ff == '0) begin
                        mk_we      = 1'b1;
                        mk_waddr   = '0;
                        mk_wdata   = req_position;
                        count_in   = COUNT_W'(1);
                        res_acc_in = 1'b1;
                     end else begin
                        mk_re      = 1'b1;
                        mk_raddr   = MARK_IDX_W'(count_ff - COUNT_W'(1));
                        shift_in   = 1'b1;
                        res_acc_in = 1'b1;
                        state_in   = ST_DIST;
                     end
                  end
                  REQ_CLEAR: begin
                     map_ctl.clear = 1'b1;
                     count_in      = '0;
                     res_acc_in    = 1'b1;
                  end
                  default: begin
                     res_acc_in = 1'b0;
                  end
               endcase
            end
         end

         ST_DIST: begin
            // Mark is in mark_q_ff: fetch the bitmap row of its distance.
            map_ctl.rd_en = 1'b1;
            inlim_in      = ({1'b0, diff} < limit);
            if ((type_ff == REQ_ADD) && shift_ff) begin
               // Move marks at or above the new position up by one slot.
               mk_we    = 1'b1;
               mk_waddr = idx_ff + MARK_IDX_W'(1);
               if (mark_q_ff >= pos_ff) begin
                  mk_wdata = mark_q_ff;
               end else begin
                  mk_wdata = pos_ff;
                  shift_in = 1'b0;
               end
            end
            state_in = ST_UPD;
         end

         ST_UPD: begin
            if ((type_ff == REQ_CHECK) && inlim_ff && map_hit) begin
               res_acc_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               if (type_ff == REQ_ADD) begin
                  map_ctl.wr_en = inlim_ff;
               end
               if (idx_ff == '0) begin
                  if (type_ff == REQ_ADD) begin
                     if (shift_ff) begin
                        mk_we    = 1'b1;
                        mk_waddr = '0;
                        mk_wdata = pos_ff;
                     end
                     count_in = count_ff + COUNT_W'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff - MARK_IDX_W'(1);
                  mk_re    = 1'b1;
                  mk_raddr = idx_ff - MARK_IDX_W'(1);
                  state_in = ST_DIST;
               end
            end
         end

         ST_DONE: begin
            // Hold until the result slot is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_cnt_in   = count_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dist_cap_ff  <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         type_ff      <= type_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         inlim_ff     <= inlim_in;
         res_acc_ff   <= res_acc_in;
         res_ovf_ff   <= res_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_acc_ff   <= rsp_acc_in;
         rsp_cnt_ff   <= rsp_cnt_in;
         rsp_ovf_ff   <= rsp_ovf_in;
         dist_cap_ff  <= dist_cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mk_we) begin
         marks_mem[mk_waddr] <= mk_wdata;
      end
      if (mk_re) begin
         mark_q_ff <= marks_mem[mk_raddr];
      end
   end

endmodule
